### hw/rtl/ins_sort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; used by ins_sort_cell and insertion_sorter.
`timescale 1ns / 1ps

package ins_sort_pkg;

    localparam int VALUE_W       = 32;
    localparam int MAX_ITEMS_DEF = 16;

    typedef logic signed [VALUE_W-1:0] value_t;

    // link between neighbouring cells
    typedef struct packed {
        logic   occ;
        logic   gt;
        value_t val;
    } link_t;

endpackage

### hw/rtl/ins_sort_cell.sv
// One cell of the insertion chain: holds one sorted entry and its occupancy.
// Depends on ins_sort_pkg.
`timescale 1ns / 1ps

module ins_sort_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 insert_en,
    input  logic                 shift_en,
    input  ins_sort_pkg::value_t new_value,
    input  ins_sort_pkg::link_t  from_lower,
    input  ins_sort_pkg::link_t  from_upper,
    output ins_sort_pkg::link_t  link
);

    logic                 occ_reg;
    logic                 occ_next;
    ins_sort_pkg::value_t val_reg;
    ins_sort_pkg::value_t val_next;
    logic                 gt_self;
    logic                 take_new;

    assign gt_self  = occ_reg && (val_reg > new_value);
    assign take_new = !from_lower.gt && (gt_self || (!occ_reg && from_lower.occ));

    always_comb
    begin
        occ_next = occ_reg;
        val_next = val_reg;
        if (shift_en)
        begin
            occ_next = from_upper.occ;
            val_next = from_upper.val;
        end
        else if (insert_en)
        begin
            if (from_lower.gt)
            begin
                occ_next = 1'b1;
                val_next = from_lower.val;
            end
            else if (take_new)
            begin
                occ_next = 1'b1;
                val_next = new_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign link.occ = occ_reg;
    assign link.gt  = gt_self;
    assign link.val = val_reg;

endmodule

### hw/rtl/insertion_sorter.sv
// Top level of the streaming stable insertion sorter: a chain of ins_sort_cell.
// Depends on ins_sort_pkg and ins_sort_cell.
`timescale 1ns / 1ps

// Takes one signed word per cycle and inserts it in place in a chain of
// MAX_ITEMS cells: every cell compares against the incoming word at once,
// and entries strictly greater move up one cell, so equal words keep their
// arrival order. Words arriving while all cells are full are dropped and
// overflow_seen is raised on every result of that set. The word with
// set_end high is inserted (or dropped) first; the chain then drains
// through the lowest cell, smallest first, one result per cycle while
// out_ready is high, with run_end on the last. in_ready stays low while
// draining, so the next set is taken only after the last result is accepted.

module insertion_sorter
#(
    parameter int MAX_ITEMS = ins_sort_pkg::MAX_ITEMS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ins_sort_pkg::value_t sample_value,
    input  logic                 set_end,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ins_sort_pkg::value_t sorted_value,
    output logic                 run_end,
    output logic                 overflow_seen
);

    ins_sort_pkg::link_t links [MAX_ITEMS];
    ins_sort_pkg::link_t lower [MAX_ITEMS];
    ins_sort_pkg::link_t upper [MAX_ITEMS];

    logic drain_reg;
    logic drain_next;
    logic dropped_reg;
    logic dropped_next;
    logic in_fire;
    logic out_fire;
    logic full;
    logic insert_en;

    assign full      = links[MAX_ITEMS-1].occ;
    assign in_ready  = !drain_reg;
    assign in_fire   = in_valid && in_ready;
    assign insert_en = in_fire && !full;

    assign out_valid     = drain_reg && links[0].occ;
    assign sorted_value  = links[0].val;
    assign run_end       = !links[1].occ;
    assign overflow_seen = dropped_reg;
    assign out_fire      = out_valid && out_ready;

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign lower[i] = '{occ: 1'b1, gt: 1'b0, val: '0};
            end
            else
            begin : g_mid_lo
                assign lower[i] = links[i-1];
            end

            if (i == MAX_ITEMS - 1)
            begin : g_last
                assign upper[i] = '{occ: 1'b0, gt: 1'b0, val: '0};
            end
            else
            begin : g_mid_hi
                assign upper[i] = links[i+1];
            end

            ins_sort_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .insert_en  (insert_en),
                .shift_en   (out_fire),
                .new_value  (sample_value),
                .from_lower (lower[i]),
                .from_upper (upper[i]),
                .link       (links[i])
            );
        end
    endgenerate

    always_comb
    begin
        drain_next   = drain_reg;
        dropped_next = dropped_reg;
        if (out_fire && run_end)
        begin
            drain_next   = 1'b0;
            dropped_next = 1'b0;
        end
        else if (in_fire)
        begin
            drain_next   = set_end;
            dropped_next = dropped_reg || full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            drain_reg   <= drain_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule
